[design/i2cpw_pkg.sv]
// ----------------------------------------------------------------------------
// i2cpw_pkg
// Types and constants shared by the potentiometer wiper write master.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cpw_pkg;

	// Register indexes on the configuration channel
	localparam logic [1:0] CFG_HALF_PERIOD = 2'd0;
	localparam logic [1:0] CFG_DEV_ADDR    = 2'd1;
	localparam logic [1:0] CFG_CMD_BASE    = 2'd2;

	// Register values after reset
	localparam logic [15:0] HALF_PERIOD_RST = 16'd100;
	localparam logic [7:0]  DEV_ADDR_RST    = 8'h5E;
	localparam logic [7:0]  CMD_BASE_RST    = 8'h10;

	// Half periods per segment and bits per byte including acknowledge
	localparam logic [3:0] START_HALVES    = 4'd2;
	localparam logic [3:0] STOP_LOW_HALVES = 4'd1;
	localparam logic [3:0] STOP_SET_HALVES = 4'd2;
	localparam logic [3:0] ACK_BIT         = 4'd8;
	localparam logic [3:0] BITS_PER_BYTE   = 4'd9;
	localparam logic [1:0] BYTES_PER_XFER  = 2'd3;
	localparam logic [1:0] BYTE_CMD        = 2'd1;

	typedef enum logic [5:0] {
		PH_IDLE      = 6'b000001,
		PH_START     = 6'b000010,
		PH_BIT_LOW   = 6'b000100,
		PH_BIT_HIGH  = 6'b001000,
		PH_STOP_LOW  = 6'b010000,
		PH_STOP_SET  = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [15:0] half_period;
		logic [7:0]  dev_addr;
		logic [7:0]  cmd_base;
	} cfg_t;

	typedef struct packed {
		phase_t      phase;
		logic [15:0] tick_cnt;
		logic [3:0]  bit_cnt;
		logic [1:0]  byte_cnt;
		logic [7:0]  shift_byte;
		logic [7:0]  held_command;
		logic [7:0]  held_value;
		logic        scl;
		logic        sda;
	} seq_state_t;

	typedef struct packed {
		logic       start_request;
		logic       wiper_select;
		logic [7:0] wiper_value;
	} tick_item_t;

	typedef struct packed {
		logic scl_level;
		logic sda_level;
		logic busy_res;
		logic done_res;
	} tick_result_t;

endpackage

`default_nettype wire

[design/i2cpw_step.sv]
// ----------------------------------------------------------------------------
// i2cpw_step
// Next-state and line-level logic of the bus sequencer for one tick.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cpw_step
	import i2cpw_pkg::*;
(
	input  wire seq_state_t   cur,
	input  wire cfg_t         cfg,
	input  wire tick_item_t   item,
	output seq_state_t        nxt,
	output tick_result_t      res
);

	logic [15:0] half_len;
	logic [15:0] tick_inc;
	logic        tick_end;
	logic [3:0]  bit_inc;
	logic [1:0]  byte_inc;
	logic [7:0]  shifted;
	logic [7:0]  next_byte;
	logic        done;

	always_comb begin
		nxt       = cur;
		done      = 1'b0;
		half_len  = (cfg.half_period == 16'd0) ? 16'd1 : cfg.half_period;
		tick_inc  = cur.tick_cnt + 16'd1;
		tick_end  = (tick_inc >= half_len);
		bit_inc   = cur.bit_cnt + 4'd1;
		byte_inc  = cur.byte_cnt + 2'd1;
		shifted   = {cur.shift_byte[6:0], 1'b0};
		next_byte = (byte_inc == BYTE_CMD) ? cur.held_command : cur.held_value;

		unique case (cur.phase)
			PH_IDLE: begin
				nxt.scl = 1'b1;
				if (item.start_request) begin
					// latch the transfer and open the start condition
					nxt.held_command = cfg.cmd_base + {7'd0, item.wiper_select};
					nxt.held_value   = item.wiper_value;
					nxt.shift_byte   = cfg.dev_addr;
					nxt.tick_cnt     = 16'd0;
					nxt.bit_cnt      = 4'd0;
					nxt.byte_cnt     = 2'd0;
					nxt.phase        = PH_START;
					nxt.sda          = 1'b0;
				end else begin
					nxt.sda = 1'b1;
				end
			end
			PH_START: begin
				if (!tick_end) begin
					nxt.tick_cnt = tick_inc;
				end else begin
					nxt.tick_cnt = 16'd0;
					if (bit_inc < START_HALVES) begin
						nxt.bit_cnt = bit_inc;
					end else begin
						nxt.bit_cnt  = 4'd0;
						nxt.byte_cnt = 2'd0;
						nxt.phase    = PH_BIT_LOW;
						nxt.scl      = 1'b0;
						nxt.sda      = cur.shift_byte[7];
					end
				end
			end
			PH_BIT_LOW: begin
				if (!tick_end) begin
					nxt.tick_cnt = tick_inc;
				end else begin
					nxt.tick_cnt = 16'd0;
					nxt.phase    = PH_BIT_HIGH;
					nxt.scl      = 1'b1;
					nxt.sda      = (cur.bit_cnt >= ACK_BIT) ? 1'b1 : cur.shift_byte[7];
				end
			end
			PH_BIT_HIGH: begin
				if (!tick_end) begin
					nxt.tick_cnt = tick_inc;
				end else begin
					nxt.tick_cnt = 16'd0;
					if (bit_inc >= BITS_PER_BYTE) begin
						nxt.bit_cnt = 4'd0;
						if (byte_inc == BYTES_PER_XFER || byte_inc == 2'd0) begin
							nxt.byte_cnt = 2'd0;
							nxt.phase    = PH_STOP_LOW;
							nxt.scl      = 1'b0;
							nxt.sda      = 1'b0;
						end else begin
							nxt.byte_cnt   = byte_inc;
							nxt.shift_byte = next_byte;
							nxt.phase      = PH_BIT_LOW;
							nxt.scl        = 1'b0;
							nxt.sda        = next_byte[7];
						end
					end else begin
						nxt.bit_cnt    = bit_inc;
						nxt.shift_byte = shifted;
						nxt.phase      = PH_BIT_LOW;
						nxt.scl        = 1'b0;
						nxt.sda        = (bit_inc >= ACK_BIT) ? 1'b1 : shifted[7];
					end
				end
			end
			PH_STOP_LOW: begin
				if (!tick_end) begin
					nxt.tick_cnt = tick_inc;
				end else begin
					nxt.tick_cnt = 16'd0;
					if (bit_inc < STOP_LOW_HALVES) begin
						nxt.bit_cnt = bit_inc;
					end else begin
						nxt.bit_cnt = 4'd0;
						nxt.phase   = PH_STOP_SET;
						nxt.scl     = 1'b1;
						nxt.sda     = 1'b0;
					end
				end
			end
			PH_STOP_SET: begin
				if (!tick_end) begin
					nxt.tick_cnt = tick_inc;
				end else begin
					nxt.tick_cnt = 16'd0;
					if (bit_inc < STOP_SET_HALVES) begin
						nxt.bit_cnt = bit_inc;
					end else begin
						nxt.bit_cnt = 4'd0;
						nxt.phase   = PH_IDLE;
						nxt.scl     = 1'b1;
						nxt.sda     = 1'b1;
						done        = 1'b1;
					end
				end
			end
			default: begin
				nxt.phase    = PH_IDLE;
				nxt.tick_cnt = 16'd0;
				nxt.bit_cnt  = 4'd0;
				nxt.byte_cnt = 2'd0;
				nxt.scl      = 1'b1;
				nxt.sda      = 1'b1;
			end
		endcase

		res.scl_level = nxt.scl;
		res.sda_level = nxt.sda;
		res.busy_res  = (nxt.phase != PH_IDLE);
		res.done_res  = done;
	end

endmodule

`default_nettype wire

[design/i2c_pot_wiper_write_master_core.sv]
// ----------------------------------------------------------------------------
// i2c_pot_wiper_write_master_core
// Write-only I2C master that sets one of two potentiometer wipers.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  tdata: wiper_value; tuser: request, select
// m_*       out        m_tvalid/m_tready  tdata: scl, sda, busy, done
// cfg_*     in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// Each input transaction is one sequencer tick and yields one output
// transaction. A tick passes an input register, then the sequencer step and
// the output register: one tick per cycle sustained while m_tready is high.
// Reset returns the sequencer to idle with both lines released and the
// registers at their defaults. A stalled output holds the result; the input
// register still takes a tick whenever the output register can drain.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_pot_wiper_write_master_core
	import i2cpw_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,

	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire [7:0]  s_tdata,   // [7:0] wiper_value
	input  wire [1:0]  s_tuser,   // [0] start_request, [1] wiper_select

	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [7:0] m_tdata,   // [0] scl_level, [1] sda_level, [2] busy_res,
	                              // [3] done_res, [7:4] zero

	input  wire        cfg_valid,
	output logic       cfg_ready,
	input  wire [1:0]  cfg_index,
	input  wire [15:0] cfg_data
);

	cfg_t         cfg_q;
	seq_state_t   state_q;
	seq_state_t   state_nxt;
	tick_item_t   item_s1;
	logic         valid_s1;
	tick_result_t res_nxt;
	tick_result_t res_s2;
	logic         valid_s2;
	logic         advance;

	// Registers are always writable; unknown indexes drop silently
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_period <= HALF_PERIOD_RST;
			cfg_q.dev_addr    <= DEV_ADDR_RST;
			cfg_q.cmd_base    <= CMD_BASE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_HALF_PERIOD: cfg_q.half_period <= cfg_data;
				CFG_DEV_ADDR:    cfg_q.dev_addr    <= cfg_data[7:0];
				CFG_CMD_BASE:    cfg_q.cmd_base    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Step a tick whenever the output register is free or draining
	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.start_request <= s_tuser[0];
			item_s1.wiper_select  <= s_tuser[1];
			item_s1.wiper_value   <= s_tdata;
		end
	end

	i2cpw_step u_step (
		.cur  (state_q),
		.cfg  (cfg_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// Advance the sequencer only on a consumed tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase        <= PH_IDLE;
			state_q.tick_cnt     <= 16'd0;
			state_q.bit_cnt      <= 4'd0;
			state_q.byte_cnt     <= 2'd0;
			state_q.shift_byte   <= 8'd0;
			state_q.held_command <= 8'd0;
			state_q.held_value   <= 8'd0;
			state_q.scl          <= 1'b1;
			state_q.sda          <= 1'b1;
			valid_s2             <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	// Hold the result while the sink stalls
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'd0, res_s2.done_res, res_s2.busy_res,
	                   res_s2.sda_level, res_s2.scl_level};

endmodule

`default_nettype wire
